@@ hdl/lji_pkg.sv @@
// ----------------------------------------------------------------------------
// lji_pkg
// Shared types, constants and helpers for the leaky joint integrator.
// ----------------------------------------------------------------------------
package lji_pkg;

  localparam int JOINT_W     = 5;
  localparam int DATA_W      = 32;
  localparam int ALPHA_W     = 17;
  localparam int STEP_W      = 24;
  localparam int LIMIT_W     = 31;
  localparam int SUM_W       = DATA_W + 2;
  localparam int IN_TDATA_W  = 104;
  localparam int OUT_TDATA_W = 72;
  localparam int CFG_ADDR_W  = 3;
  localparam int MUL_A_W     = DATA_W + 1;
  localparam int MUL_B_W     = STEP_W + 1;
  localparam int PROD_W      = MUL_A_W + MUL_B_W;
  localparam int STATE_W     = 2 * DATA_W;

  localparam logic [ALPHA_W-1:0]       ALPHA_ONE = 17'h10000;
  localparam logic signed [DATA_W-1:0] DATA_MAX  = 32'sh7fffffff;
  localparam logic signed [DATA_W-1:0] DATA_MIN  = 32'sh80000000;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_ALPHA_VELOCITY       = 3'd0,
    REG_ALPHA_POSITION       = 3'd1,
    REG_TIME_STEP            = 3'd2,
    REG_VELOCITY_LOWER       = 3'd3,
    REG_VELOCITY_UPPER       = 3'd4,
    REG_POSITION_LOWER       = 3'd5,
    REG_POSITION_UPPER       = 3'd6,
    REG_POSITION_ERROR_LIMIT = 3'd7
  } cfg_reg_t;

  typedef enum logic {
    CMD_INTEGRATE = 1'b0,
    CMD_INIT      = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_INTEGRATE,
    KIND_INIT,
    KIND_SKIP
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_VMUL,
    ST_AMUL,
    ST_VSUM,
    ST_VCLAMP,
    ST_PMUL,
    ST_SMUL,
    ST_PSUM,
    ST_PCLAMP,
    ST_DONE
  } state_t;

  typedef struct packed {
    kind_t                     kind;
    logic [JOINT_W-1:0]        joint;
    logic signed [DATA_W-1:0]  acceleration;
    logic signed [DATA_W-1:0]  velocity_in;
    logic signed [DATA_W-1:0]  position_in;
  } item_t;

  typedef struct packed {
    logic [ALPHA_W-1:0]        alpha_velocity;
    logic [ALPHA_W-1:0]        alpha_position;
    logic [STEP_W-1:0]         time_step;
    logic signed [DATA_W-1:0]  velocity_lower;
    logic signed [DATA_W-1:0]  velocity_upper;
    logic signed [DATA_W-1:0]  position_lower;
    logic signed [DATA_W-1:0]  position_upper;
    logic [LIMIT_W-1:0]        position_error_limit;
  } cfg_t;

  function automatic logic signed [DATA_W-1:0] sat_data(input logic signed [SUM_W-1:0] x);
    logic signed [DATA_W-1:0] r;
    if (x > SUM_W'(DATA_MAX)) begin
      r = DATA_MAX;
    end else if (x < SUM_W'(DATA_MIN)) begin
      r = DATA_MIN;
    end else begin
      r = x[DATA_W-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [DATA_W-1:0] clamp_data(input logic signed [DATA_W-1:0] x,
                                                         input logic signed [DATA_W-1:0] lo,
                                                         input logic signed [DATA_W-1:0] hi);
    logic signed [DATA_W-1:0] r;
    if (x >= hi) begin
      r = hi;
    end else if (x <= lo) begin
      r = lo;
    end else begin
      r = x;
    end
    return r;
  endfunction

endpackage

@@ hdl/lji_ram.sv @@
// ----------------------------------------------------------------------------
// lji_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module lji_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hdl/lji_front.sv @@
// ----------------------------------------------------------------------------
// lji_front
// Input acceptance, command classification and a two-entry item queue.
// ----------------------------------------------------------------------------
module lji_front #(
  parameter int NUM_JOINTS = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [lji_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  input  logic                              s_axis_tuser,
  output logic                              q_valid,
  output lji_pkg::item_t                    q_item,
  input  logic                              q_pop
);

  import lji_pkg::*;

  localparam int DEPTH = 2;

  item_t              entry [DEPTH];
  item_t              incoming;
  logic               wr_ptr;
  logic               rd_ptr;
  logic [1:0]         count;
  logic               push;
  logic               pop;
  logic [JOINT_W-1:0] joint;

  always_comb begin
    joint                 = s_axis_tdata[4:0];
    incoming.joint        = joint;
    incoming.acceleration = s_axis_tdata[36:5];
    incoming.velocity_in  = s_axis_tdata[68:37];
    incoming.position_in  = s_axis_tdata[100:69];
    if (32'(joint) >= 32'(NUM_JOINTS)) begin
      incoming.kind = KIND_SKIP;
    end else if (s_axis_tuser == CMD_INIT) begin
      incoming.kind = KIND_INIT;
    end else begin
      incoming.kind = KIND_INTEGRATE;
    end
  end

  assign s_axis_tready = (count != 2'(DEPTH));
  assign q_valid       = (count != 2'd0);
  assign q_item        = entry[rd_ptr];
  assign push          = s_axis_tvalid && s_axis_tready;
  assign pop           = q_pop && q_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ hdl/lji_back.sv @@
// ----------------------------------------------------------------------------
// lji_back
// Joint state store, shared-multiplier update sequencer and result register.
// ----------------------------------------------------------------------------
module lji_back #(
  parameter int NUM_JOINTS = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  lji_pkg::cfg_t                     cfg,
  input  logic                              q_valid,
  input  lji_pkg::item_t                    q_item,
  output logic                              q_pop,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [lji_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

  import lji_pkg::*;

  localparam int AW = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;
  localparam logic signed [PROD_W-1:0] HALF16 = PROD_W'(64'sd32768);
  localparam logic signed [PROD_W-1:0] HALF24 = PROD_W'(64'sd8388608);

  state_t                     state;
  state_t                     state_next;
  item_t                      cur;
  logic                       old_vld;
  logic [NUM_JOINTS-1:0]      valid;
  logic                       ram_re;
  logic                       ram_we;
  logic [AW-1:0]              ram_raddr;
  logic [AW-1:0]              ram_waddr;
  logic [STATE_W-1:0]         ram_wdata;
  logic [STATE_W-1:0]         ram_rdata;
  logic signed [DATA_W-1:0]   v_old;
  logic signed [DATA_W-1:0]   p_old;
  logic signed [DATA_W-1:0]   v_blend;
  logic signed [DATA_W-1:0]   p_blend;
  logic signed [DATA_W-1:0]   v_sum;
  logic signed [DATA_W-1:0]   p_sum;
  logic signed [DATA_W-1:0]   v_new;
  logic signed [DATA_W-1:0]   p_lim;
  logic signed [DATA_W-1:0]   lim_lo;
  logic signed [DATA_W-1:0]   lim_hi;
  logic signed [DATA_W-1:0]   res_v;
  logic signed [DATA_W-1:0]   res_p;
  logic signed [MUL_A_W-1:0]  mul_a;
  logic signed [MUL_B_W-1:0]  mul_b;
  logic signed [PROD_W-1:0]   prod;
  logic signed [PROD_W-1:0]   r16;
  logic signed [PROD_W-1:0]   r24;
  logic [ALPHA_W-1:0]         av_eff;
  logic [ALPHA_W-1:0]         ap_eff;
  logic                       out_free;
  logic                       advance;
  logic                       out_valid;
  logic [OUT_TDATA_W-1:0]     out_data;

  lji_ram #(
    .WIDTH (STATE_W),
    .DEPTH (NUM_JOINTS)
  ) u_state_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // alpha above one acts as one
  assign av_eff = cfg.alpha_velocity[ALPHA_W-1] ? ALPHA_ONE : cfg.alpha_velocity;
  assign ap_eff = cfg.alpha_position[ALPHA_W-1] ? ALPHA_ONE : cfg.alpha_position;

  assign v_old = old_vld ? $signed(ram_rdata[DATA_W-1:0]) : '0;
  assign p_old = old_vld ? $signed(ram_rdata[STATE_W-1:DATA_W]) : '0;

  assign r16 = (prod + HALF16) >>> 16;
  assign r24 = (prod + HALF24) >>> 24;

  assign ram_raddr = AW'(q_item.joint);
  assign ram_waddr = AW'(cur.joint);
  assign ram_wdata = {res_p, res_v};
  assign ram_we    = advance && (cur.kind != KIND_SKIP);

  assign out_free      = !out_valid || m_axis_tready;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  always_comb begin
    case (cur.kind)
      KIND_INIT: begin
        res_v = cur.velocity_in;
        res_p = cur.position_in;
      end
      KIND_INTEGRATE: begin
        res_v = v_new;
        res_p = clamp_data(p_lim, cfg.position_lower, cfg.position_upper);
      end
      default: begin
        res_v = '0;
        res_p = '0;
      end
    endcase
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_VMUL: begin
        mul_a = MUL_A_W'(cur.velocity_in) - MUL_A_W'(v_old);
        mul_b = $signed(MUL_B_W'(av_eff));
      end
      ST_AMUL: begin
        mul_a = MUL_A_W'(cur.acceleration);
        mul_b = $signed(MUL_B_W'(cfg.time_step));
      end
      ST_PMUL: begin
        mul_a = MUL_A_W'(cur.position_in) - MUL_A_W'(p_old);
        mul_b = $signed(MUL_B_W'(ap_eff));
      end
      ST_SMUL: begin
        mul_a = MUL_A_W'(v_new);
        mul_b = $signed(MUL_B_W'(cfg.time_step));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    ram_re     = 1'b0;
    advance    = 1'b0;
    case (state)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop  = 1'b1;
          ram_re = 1'b1;
          state_next = (q_item.kind == KIND_INTEGRATE) ? ST_VMUL : ST_DONE;
        end
      end
      ST_VMUL:   state_next = ST_AMUL;
      ST_AMUL:   state_next = ST_VSUM;
      ST_VSUM:   state_next = ST_VCLAMP;
      ST_VCLAMP: state_next = ST_PMUL;
      ST_PMUL:   state_next = ST_SMUL;
      ST_SMUL:   state_next = ST_PSUM;
      ST_PSUM:   state_next = ST_PCLAMP;
      ST_PCLAMP: state_next = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          advance    = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      valid     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ram_we) begin
        valid[ram_waddr] <= 1'b1;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (q_pop) begin
      cur     <= q_item;
      old_vld <= valid[ram_raddr];
    end
    case (state)
      ST_AMUL: v_blend <= DATA_W'(SUM_W'(v_old) + r16[SUM_W-1:0]);
      ST_VSUM: v_sum <= sat_data(SUM_W'(v_blend) + $signed(r24[SUM_W-1:0]));
      ST_VCLAMP: v_new <= clamp_data(v_sum, cfg.velocity_lower, cfg.velocity_upper);
      ST_PMUL: begin
        lim_lo <= sat_data(SUM_W'(cur.position_in) -
                           $signed(SUM_W'(cfg.position_error_limit)));
        lim_hi <= sat_data(SUM_W'(cur.position_in) +
                           $signed(SUM_W'(cfg.position_error_limit)));
      end
      ST_SMUL: p_blend <= DATA_W'(SUM_W'(p_old) + r16[SUM_W-1:0]);
      ST_PSUM: p_sum <= sat_data(SUM_W'(p_blend) + $signed(r24[SUM_W-1:0]));
      ST_PCLAMP: p_lim <= clamp_data(p_sum, lim_lo, lim_hi);
      default: ;
    endcase
    if (advance) begin
      out_data <= {3'b000, res_p, res_v, cur.joint};
    end
  end

endmodule

@@ hdl/leaky_joint_integrator_top.sv @@
// ----------------------------------------------------------------------------
// leaky_joint_integrator_top
// Per-joint leaky velocity and position integrator with saturating clamps.
// ----------------------------------------------------------------------------
// sequencing: an integrate item steps through the velocity multiply, sum and clamp
//   states, then the position ones; initialize and out-of-range items go straight
//   to the result. The shared multiplier sequence takes one item at a time; the next
//   starts only after the last result is taken into the output register
// reset: synchronous; clears the queue, sequencer, result register and
//   joint valid bits so every joint reads as zero, and restores the registers
module leaky_joint_integrator_top #(
  parameter int NUM_JOINTS = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // joint, acceleration, velocity_in, position_in, zero pad
  input  logic [lji_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // command
  input  logic                              s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // joint_out, velocity_out, position_out, zero pad
  output logic [lji_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  input  logic                              cfg_we,
  input  logic [lji_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [lji_pkg::DATA_W-1:0]        cfg_data
);

  import lji_pkg::*;

  cfg_t  cfg;
  logic  q_valid;
  item_t q_item;
  logic  q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.alpha_velocity       <= '0;
      cfg.alpha_position       <= '0;
      cfg.time_step            <= '0;
      cfg.velocity_lower       <= DATA_MIN;
      cfg.velocity_upper       <= DATA_MAX;
      cfg.position_lower       <= DATA_MIN;
      cfg.position_upper       <= DATA_MAX;
      cfg.position_error_limit <= '1;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_addr))
        REG_ALPHA_VELOCITY:       cfg.alpha_velocity       <= cfg_data[ALPHA_W-1:0];
        REG_ALPHA_POSITION:       cfg.alpha_position       <= cfg_data[ALPHA_W-1:0];
        REG_TIME_STEP:            cfg.time_step            <= cfg_data[STEP_W-1:0];
        REG_VELOCITY_LOWER:       cfg.velocity_lower       <= cfg_data;
        REG_VELOCITY_UPPER:       cfg.velocity_upper       <= cfg_data;
        REG_POSITION_LOWER:       cfg.position_lower       <= cfg_data;
        REG_POSITION_UPPER:       cfg.position_upper       <= cfg_data;
        REG_POSITION_ERROR_LIMIT: cfg.position_error_limit <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  lji_front #(
    .NUM_JOINTS (NUM_JOINTS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop)
  );

  lji_back #(
    .NUM_JOINTS (NUM_JOINTS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

@@ hdl/lji_checker.sv @@
// ----------------------------------------------------------------------------
// lji_checker
// Port-level checks for the leaky joint integrator, bound to the top level.
// ----------------------------------------------------------------------------
module lji_checker #(
  parameter int NUM_JOINTS = 32
) (
  input logic                              clk,
  input logic                              rst,
  input logic                              s_axis_tvalid,
  input logic                              s_axis_tready,
  input logic [lji_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  input logic                              s_axis_tuser,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [lji_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  input logic                              cfg_we,
  input logic [lji_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input logic [lji_pkg::DATA_W-1:0]        cfg_data
);

  import lji_pkg::*;

  logic unused_inputs;
  assign unused_inputs = s_axis_tvalid ^ (^s_axis_tdata) ^ s_axis_tuser ^ cfg_we ^
                         (^cfg_addr) ^ (^cfg_data);

  // no result right after reset
  a_out_idle_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !m_axis_tvalid)
    else $error("result valid right after reset");

  // queue is empty and accepting right after reset
  a_in_ready_after_reset: assert property (@(posedge clk)
    $past(rst) |-> s_axis_tready)
    else $error("input not ready after reset");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // out-of-range joint returns zeros
  a_skip_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (32'(m_axis_tdata[JOINT_W-1:0]) >= 32'(NUM_JOINTS))
      |-> (m_axis_tdata[68:5] == '0))
    else $error("out-of-range joint returned nonzero values");

endmodule

bind leaky_joint_integrator_top lji_checker #(.NUM_JOINTS(NUM_JOINTS)) u_checker (.*);
